// File: rtl/ldotw_pkg.sv
package ldotw_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int TIME_BITS   = 48;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = QA_W + 1;
    localparam int TPW_W       = 40;
    localparam int SPS_W       = 20;
    localparam int WGT_W       = 64;
    localparam int PIN_W       = 8;
    localparam int REC_W       = TIME_BITS + WGT_W;
    localparam int DCNT_W      = $clog2(WGT_W);

    localparam logic [TPW_W-1:0] TPW_RESET = TPW_W'(1000000);
    localparam logic [SPS_W-1:0] SPS_RESET = SPS_W'(1000);

    // configuration register indexes
    localparam logic CFG_TPW = 1'b0;
    localparam logic CFG_SPS = 1'b1;

    // input command codes
    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic [TIME_BITS-1:0] start;
        logic [WGT_W-1:0]     weight;
    } rec_t;

endpackage

// File: rtl/ldotw_ram.sv
module ldotw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/ldotw_div.sv
module ldotw_div
    import ldotw_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WGT_W-1:0] dividend,
    input  logic [SPS_W-1:0] divisor,
    output logic             done,
    output logic [WGT_W-1:0] quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [SPS_W-1:0]  rem_reg;
    logic [WGT_W-1:0]  quo_reg;
    logic [SPS_W-1:0]  dvs_reg;
    logic [SPS_W:0]    rem_sh;
    logic              fits;

    // one restoring step: shift in next dividend bit, try subtract
    always_comb begin
        rem_sh = {rem_reg, quo_reg[WGT_W-1]};
        fits   = rem_sh >= {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= fits ? SPS_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[SPS_W-1:0];
                quo_reg <= {quo_reg[WGT_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(WGT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/led_duty_off_time_window_top.sv
// LED off-time window tracker.
// Input beats on s_* carry one LED-change event (s_tuser = 0) or a clear
// command (s_tuser = 1). Each beat gives exactly one result beat on m_*:
// m_tdata is the required off time in ticks, m_tuser flags a record that
// was dropped because the record queue was full.
// Configuration is written through cfg_wr_en/cfg_addr/cfg_wr_data, index 0
// ticks per window, index 1 states per second; the user must write it only
// while the block is idle, which the block itself does not enforce.
// One item at a time: s_tready is high only while the sequencer is idle.
// An event first walks any expired records out of the window, then runs the
// 64-step serial divider; a clear command goes straight to the output.
// Records sit in a single-port-write, registered-read RAM, walked oldest first.
// A synchronous low aresetn empties the window, restores the register
// reset values and drops any pending result. When the receiver stalls the
// result waits in the output register; the sequencer holds its last step
// until that register is free, so nothing is lost.
module led_duty_off_time_window_top
    import ldotw_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // [7:0] from_pins, [15:8] to_pins, [63:16] unset_time, [111:64] set_time
    input  logic [111:0]       s_tdata,
    // [0] command
    input  logic               s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    // [39:0] off_time
    output logic [TPW_W-1:0]   m_tdata,
    // [0] overflow
    output logic               m_tuser,
    input  logic               cfg_wr_en,
    input  logic               cfg_addr,
    input  logic [TPW_W-1:0]   cfg_wr_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_EV_RD, S_EV_CHK, S_REC, S_APPEND, S_DIV_GO, S_DIV_WAIT, S_OUT
    } state_t;

    state_t               state_reg;
    logic [TPW_W-1:0]     tpw_reg;
    logic [SPS_W-1:0]     sps_reg;
    logic [QA_W-1:0]      head_reg;
    logic [QC_W-1:0]      count_reg;
    logic [WGT_W-1:0]     total_reg;
    logic [TIME_BITS-1:0] last_reg;
    logic                 tvalid_reg;
    logic [PIN_W-1:0]     from_reg;
    logic [TIME_BITS-1:0] end_reg;
    logic [TIME_BITS-1:0] next_reg;
    logic [TIME_BITS-1:0] limit_reg;
    logic [WGT_W-1:0]     w_reg;
    logic                 ovf_reg;
    logic [TPW_W-1:0]     off_reg;
    logic                 mvalid_reg;
    logic [TPW_W-1:0]     mdata_reg;
    logic                 muser_reg;

    logic [PIN_W-1:0]     in_from;
    logic [PIN_W-1:0]     in_to;
    logic [TIME_BITS-1:0] in_unset;
    logic [TIME_BITS-1:0] in_set;
    logic [TIME_BITS-1:0] in_t;
    logic                 evict_on;
    logic [TIME_BITS-1:0] dur;
    logic [55:0]          prod;
    logic [WGT_W-1:0]     w_calc;
    logic [QC_W-1:0]      slot_sum;
    logic [QA_W-1:0]      slot;
    logic [QA_W-1:0]      head_inc;
    logic                 ram_we;
    rec_t                 ram_wdata;
    rec_t                 ram_rdata;
    logic                 div_start;
    logic                 div_done;
    logic [WGT_W-1:0]     div_q;
    logic [SPS_W-1:0]     div_d;
    logic                 out_free;

    // unpack the input beat and derive event timing
    always_comb begin
        in_from  = s_tdata[7:0];
        in_to    = s_tdata[15:8];
        in_unset = s_tdata[63:16];
        in_set   = s_tdata[111:64];
        in_t     = (in_to < in_from) ? in_set : in_unset;
        evict_on = in_set > {{(TIME_BITS-TPW_W){1'b0}}, tpw_reg};
    end

    // record weight: (from - 1) * duration, wrapping to 64 bits
    always_comb begin
        dur    = end_reg - last_reg;
        prod   = {{(56-PIN_W){1'b0}}, PIN_W'(from_reg - 1'b1)} * {8'd0, dur};
        w_calc = (from_reg == '0) ? (WGT_W'(0) - {{(WGT_W-TIME_BITS){1'b0}}, dur})
                                  : {{(WGT_W-56){1'b0}}, prod};
    end

    // queue slot arithmetic
    always_comb begin
        slot_sum = {1'b0, head_reg} + count_reg;
        slot     = (slot_sum >= QC_W'(QUEUE_DEPTH)) ?
                   QA_W'(slot_sum - QC_W'(QUEUE_DEPTH)) : slot_sum[QA_W-1:0];
        head_inc = (head_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    end

    assign ram_we           = (state_reg == S_APPEND) && (count_reg != QC_W'(QUEUE_DEPTH));
    assign ram_wdata.start  = last_reg;
    assign ram_wdata.weight = w_reg;
    assign div_start        = (state_reg == S_DIV_GO);
    assign div_d            = (sps_reg == '0) ? SPS_W'(1) : sps_reg;
    assign out_free         = !mvalid_reg || m_tready;

    ldotw_ram #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (slot),
        .wr_data (ram_wdata),
        .rd_addr (head_reg),
        .rd_data (ram_rdata)
    );

    ldotw_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (total_reg),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    // sequencer, timing state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            tpw_reg    <= TPW_RESET;
            sps_reg    <= SPS_RESET;
            head_reg   <= '0;
            count_reg  <= '0;
            total_reg  <= '0;
            last_reg   <= '0;
            tvalid_reg <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_TPW: tpw_reg <= cfg_wr_data;
                    CFG_SPS: sps_reg <= cfg_wr_data[SPS_W-1:0];
                    default: ;
                endcase
            end
            // drop the taken beat; S_OUT loads the register itself
            if (mvalid_reg && m_tready && state_reg != S_OUT) begin
                mvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        from_reg  <= in_from;
                        ovf_reg   <= 1'b0;
                        limit_reg <= in_set - {{(TIME_BITS-TPW_W){1'b0}}, tpw_reg};
                        if (in_from != '0 || in_to != '0) begin
                            end_reg  <= in_t;
                            next_reg <= in_t;
                        end else begin
                            end_reg  <= in_unset;
                            next_reg <= in_set;
                        end
                        if (s_tuser == CMD_CLEAR) begin
                            head_reg   <= '0;
                            count_reg  <= '0;
                            total_reg  <= '0;
                            last_reg   <= '0;
                            tvalid_reg <= 1'b0;
                            off_reg    <= '0;
                            state_reg  <= S_OUT;
                        end else if (!tvalid_reg) begin
                            last_reg   <= (in_from != '0 || in_to != '0) ? in_t : in_set;
                            tvalid_reg <= 1'b1;
                            state_reg  <= S_DIV_GO;
                        end else if (evict_on) begin
                            state_reg <= S_EV_RD;
                        end else begin
                            state_reg <= S_REC;
                        end
                    end
                end
                // present the oldest record to the RAM
                S_EV_RD: begin
                    state_reg <= (count_reg == '0) ? S_REC : S_EV_CHK;
                end
                // drop the oldest record if it left the window
                S_EV_CHK: begin
                    if (ram_rdata.start > limit_reg) begin
                        state_reg <= S_REC;
                    end else begin
                        total_reg <= total_reg - ram_rdata.weight;
                        head_reg  <= head_inc;
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_EV_RD;
                    end
                end
                S_REC: begin
                    w_reg     <= w_calc;
                    state_reg <= (end_reg > last_reg) ? S_APPEND : S_DIV_GO;
                    if (end_reg <= last_reg) begin
                        last_reg <= next_reg;
                    end
                end
                S_APPEND: begin
                    if (count_reg == QC_W'(QUEUE_DEPTH)) begin
                        ovf_reg <= 1'b1;
                    end else begin
                        count_reg <= count_reg + 1'b1;
                        total_reg <= total_reg + w_reg;
                    end
                    last_reg  <= next_reg;
                    state_reg <= S_DIV_GO;
                end
                S_DIV_GO: begin
                    state_reg <= S_DIV_WAIT;
                end
                // cap the quotient; a negative total gives zero
                S_DIV_WAIT: begin
                    if (div_done) begin
                        if (total_reg[WGT_W-1]) begin
                            off_reg <= '0;
                        end else if (div_q > {{(WGT_W-TPW_W){1'b0}}, tpw_reg}) begin
                            off_reg <= tpw_reg;
                        end else begin
                            off_reg <= div_q[TPW_W-1:0];
                        end
                        state_reg <= S_OUT;
                    end
                end
                // hold until the output register is free
                S_OUT: begin
                    if (out_free) begin
                        mvalid_reg <= 1'b1;
                        mdata_reg  <= off_reg;
                        muser_reg  <= ovf_reg;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

endmodule

// File: tb/led_duty_off_time_window_top_tb.sv
module led_duty_off_time_window_top_tb;
    import ldotw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int SETTLE_CYCLES  = 300;

    typedef struct {
        logic                 cmd;
        logic [PIN_W-1:0]     from_pins;
        logic [PIN_W-1:0]     to_pins;
        logic [TIME_BITS-1:0] unset_time;
        logic [TIME_BITS-1:0] set_time;
    } led_evt_t;

    typedef struct {
        logic [TPW_W-1:0] off_time;
        logic             overflow;
    } off_res_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [111:0]       s_tdata = '0;
    logic               s_tuser = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TPW_W-1:0]   m_tdata;
    logic               m_tuser;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_addr = CFG_TPW;
    logic [TPW_W-1:0]   cfg_wr_data = '0;

    led_duty_off_time_window_top DUT (.*);

    always #6 aclk = ~aclk;

    // pending beats, expected results
    led_evt_t pending_evts[$];
    off_res_t expected_offs[$];

    // predictor state
    logic [TPW_W-1:0]     win_ticks;
    logic [SPS_W-1:0]     sps_div;
    logic [TIME_BITS-1:0] rec_start_q[QUEUE_DEPTH];
    logic [WGT_W-1:0]     rec_weight_q[QUEUE_DEPTH];
    int                   q_head, q_count;
    logic [WGT_W-1:0]     run_weight;
    logic [TIME_BITS-1:0] prev_set;
    logic                 have_time;

    int  err_cnt = 0;
    int  n_events = 0, n_clears = 0, n_ovf = 0, n_results = 0;
    bit  in_fire = 0, out_fire = 0;
    bit  no_idle = 0;
    bit  hold_req = 0;
    int  hold_left = 0;
    int  quiet_cycles = 0;

    function automatic void clear_window();
        q_head = 0;
        q_count = 0;
        run_weight = '0;
        prev_set = '0;
        have_time = 1'b0;
    endfunction

    // apply one beat to the window and return the off time it calls for
    function automatic off_res_t window_off_time(led_evt_t e);
        off_res_t             r;
        logic [TIME_BITS-1:0] rec_end, next_start, limit, dur;
        logic [WGT_W-1:0]     w, q, dv;
        int                   slot;
        r.overflow = 1'b0;
        if (e.cmd == CMD_CLEAR) begin
            clear_window();
            r.off_time = '0;
            return r;
        end
        rec_end = e.unset_time;
        next_start = e.set_time;
        if (e.from_pins != 0 || e.to_pins != 0) begin
            rec_end = (e.to_pins < e.from_pins) ? e.set_time : e.unset_time;
            next_start = rec_end;
        end
        if (have_time) begin
            // drop records that fell out of the window
            if ({16'b0, e.set_time} > {24'b0, win_ticks}) begin
                limit = e.set_time - TIME_BITS'(win_ticks);
                while (q_count > 0 && rec_start_q[q_head] <= limit) begin
                    run_weight -= rec_weight_q[q_head];
                    q_head = (q_head + 1) % QUEUE_DEPTH;
                    q_count--;
                end
            end
            if (rec_end > prev_set) begin
                dur = rec_end - prev_set;
                w = ({56'b0, e.from_pins} - 64'd1) * {16'b0, dur};
                if (q_count >= QUEUE_DEPTH) begin
                    r.overflow = 1'b1;
                end else begin
                    slot = (q_head + q_count) % QUEUE_DEPTH;
                    rec_start_q[slot] = prev_set;
                    rec_weight_q[slot] = w;
                    q_count++;
                    run_weight += w;
                end
            end
        end
        prev_set = next_start;
        have_time = 1'b1;
        if (run_weight[WGT_W-1]) begin
            r.off_time = '0;
        end else begin
            dv = (sps_div == 0) ? 64'd1 : {44'b0, sps_div};
            q = run_weight / dv;
            r.off_time = (q > {24'b0, win_ticks}) ? win_ticks : q[TPW_W-1:0];
        end
        return r;
    endfunction

    // drive input beats
    always @(negedge aclk) begin
        led_evt_t e;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (pending_evts.size() > 0 && (no_idle || $urandom_range(99) >= 13)) begin
                e = pending_evts.pop_front();
                s_tdata <= {e.set_time, e.unset_time, e.to_pins, e.from_pins};
                s_tuser <= e.cmd;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // drive result ready, with long holds on request
    always @(negedge aclk) begin
        if (hold_req && hold_left == 0) begin
            hold_left = 3000;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= 13);
        end
    end

    // predict on accepted inputs, check accepted results
    always @(posedge aclk) begin
        led_evt_t e;
        off_res_t x;
        in_fire <= aresetn && s_tvalid && s_tready;
        out_fire <= aresetn && m_tvalid && m_tready;
        if (aresetn && s_tvalid && s_tready) begin
            e.cmd = s_tuser;
            {e.set_time, e.unset_time, e.to_pins, e.from_pins} = s_tdata;
            if (e.cmd == CMD_CLEAR) n_clears++;
            else n_events++;
            expected_offs.push_back(window_off_time(e));
        end
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (m_tuser) n_ovf++;
            if (expected_offs.size() == 0) begin
                $error("unexpected result beat: off_time %0d overflow %0b", m_tdata, m_tuser);
                err_cnt++;
            end else begin
                x = expected_offs.pop_front();
                if (m_tdata !== x.off_time) begin
                    $error("off_time: expected %0d, got %0d", x.off_time, m_tdata);
                    err_cnt++;
                end
                if (m_tuser !== x.overflow) begin
                    $error("overflow: expected %0b, got %0b", x.overflow, m_tuser);
                    err_cnt++;
                end
            end
        end
    end

    // stop the run if nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [TIME_BITS-1:0] rand_time();
        return TIME_BITS'({$urandom, $urandom});
    endfunction

    function automatic led_evt_t mk_evt(logic [7:0] fp, logic [7:0] tp,
                                        logic [47:0] ut, logic [47:0] st);
        led_evt_t e;
        e.cmd = CMD_EVENT;
        e.from_pins = fp;
        e.to_pins = tp;
        e.unset_time = ut;
        e.set_time = st;
        return e;
    endfunction

    function automatic led_evt_t mk_clear();
        led_evt_t e;
        e = mk_evt(8'($urandom), 8'($urandom), rand_time(), rand_time());
        e.cmd = CMD_CLEAR;
        return e;
    endfunction

    // wait until the block is idle, then write one register
    task automatic write_reg(logic idx, logic [TPW_W-1:0] val);
        wait (pending_evts.size() == 0 && expected_offs.size() == 0 && !s_tvalid);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_addr <= idx;
        cfg_wr_data <= val;
        cfg_wr_en <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_TPW) win_ticks = val;
        else sps_div = val[SPS_W-1:0];
    endtask

    // well-formed timeline of events with random content, some noise
    task automatic push_random(int n);
        logic [TIME_BITS-1:0] cur, ut, st;
        logic [7:0]           fp, tp;
        int                   k;
        cur = TIME_BITS'($urandom_range(5000));
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 4) begin
                pending_evts.push_back(mk_clear());
                cur = $urandom_range(1) ? rand_time() >> 2 : TIME_BITS'($urandom_range(5000));
            end else if (k < 12) begin
                pending_evts.push_back(mk_evt(8'($urandom), 8'($urandom),
                                              rand_time(), rand_time()));
            end else begin
                fp = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(4));
                tp = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(4));
                if ($urandom_range(7) == 0) fp = '0;
                ut = cur + TIME_BITS'($urandom_range(3000));
                st = ut + ($urandom_range(9) == 0 ? TIME_BITS'({$urandom}) :
                           TIME_BITS'($urandom_range(3000)));
                pending_evts.push_back(mk_evt(fp, tp, ut, st));
                cur = st;
                if (cur[TIME_BITS-1:TIME_BITS-2] == 2'b11) begin
                    pending_evts.push_back(mk_clear());
                    cur = TIME_BITS'($urandom_range(5000));
                end
            end
        end
    endtask

    initial begin
        win_ticks = TPW_RESET;
        sps_div = SPS_RESET;
        clear_window();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: first event, zero pins, falling and rising pins, no-duration,
        // negative weight, far eviction, clears
        pending_evts.push_back(mk_clear());
        pending_evts.push_back(mk_evt(8'd3, 8'd3, 48'd100, 48'd200));
        pending_evts.push_back(mk_evt(8'd0, 8'd0, 48'd500, 48'd900));
        pending_evts.push_back(mk_evt(8'd255, 8'd0, 48'd1500, 48'd2500));
        pending_evts.push_back(mk_evt(8'd2, 8'd7, 48'd2500, 48'd2600));
        pending_evts.push_back(mk_evt(8'd0, 8'd4, 48'd9000, 48'd9100));
        pending_evts.push_back(mk_evt(8'd255, 8'd255, 48'd600000, 48'd700000));
        pending_evts.push_back(mk_evt(8'd1, 8'd1, 48'd700000, 48'd700010));
        pending_evts.push_back(mk_evt(8'd5, 8'd2, 48'd0, 48'd800000));
        pending_evts.push_back(mk_evt(8'd9, 8'd9, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF));
        pending_evts.push_back(mk_clear());
        pending_evts.push_back(mk_evt(8'd0, 8'd0, 48'd0, 48'd0));
        pending_evts.push_back(mk_evt(8'd128, 8'd64, 48'hAAAA_AAAA_AAAA, 48'hFFFF_FFFF_FFFF));
        pending_evts.push_back(mk_clear());

        write_reg(CFG_TPW, 40'hFF_FFFF_FFFF);
        write_reg(CFG_SPS, 40'd1);
        // fill the record queue past its depth with no eviction
        pending_evts.push_back(mk_clear());
        for (int i = 0; i < 70; i++)
            pending_evts.push_back(mk_evt(8'($urandom_range(255, 2)), 8'd255,
                                          48'(10 * (i + 1)), 48'(10 * (i + 1) + 3)));
        // a far set time walks the whole queue out
        pending_evts.push_back(mk_evt(8'd3, 8'd3, 48'd2000, 48'hFFFF_FFFF_FFFF));
        push_random(100);

        // receiver holds off while the sender keeps offering
        hold_req = 1;
        write_reg(CFG_TPW, 40'd1);
        write_reg(CFG_SPS, 40'hF_FFFF);
        push_random(100);

        write_reg(CFG_TPW, 40'd5000);
        write_reg(CFG_SPS, 40'd0);
        no_idle = 1;
        push_random(120);
        wait (pending_evts.size() == 0);
        no_idle = 0;

        write_reg(CFG_TPW, 40'd20000);
        write_reg(CFG_SPS, 40'd7);
        push_random(120);

        write_reg(CFG_TPW, TPW_RESET);
        write_reg(CFG_SPS, TPW_W'(SPS_RESET));
        push_random(80);

        wait (pending_evts.size() == 0 && expected_offs.size() == 0 && !s_tvalid);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        $display("Covered %0d LED events and %0d clears, %0d result beats, %0d overflows,",
                 n_events, n_clears, n_results, n_ovf);
        $display("across six window/divisor settings including both extremes and a zero divisor.");
        if (err_cnt == 0 && expected_offs.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
